/* design/tdm_pkg.sv */
// ----------------------------------------------------------------------------
// tdm_pkg: shared types and constants for the tile deduplicator
// Item structs, chain link struct, register codes, sequencer states and the
// byte reversal used to build the mirrored probe rows.
// ----------------------------------------------------------------------------
package tdm_pkg;

    // Store geometry
    localparam int STORE_TILES_DEF = 256;
    localparam int TILE_ROWS       = 8;
    localparam int ROW_W           = 16;
    localparam int TILE_W          = TILE_ROWS * ROW_W;
    localparam int N_VARIANTS      = 4;

    // Probe variant slots, in search priority order
    localparam int V_PLAIN = 0;
    localparam int V_VFLIP = 1;
    localparam int V_HFLIP = 2;
    localparam int V_BOTH  = 3;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;
    localparam logic [CFG_IW-1:0] CFG_BITS_PER_PIXEL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DEDUP_ENABLE   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MIRROR_ENABLE  = 2'd2;
    localparam logic [1:0] BPP_ONE_PLANE = 2'd1;
    localparam logic [1:0] BPP_RESET     = 2'd2;

    typedef logic [ROW_W-1:0]                  t_row;
    typedef logic [TILE_W-1:0]                 t_tile;
    typedef logic [N_VARIANTS-1:0][ROW_W-1:0]  t_probe;

    typedef struct packed {
        t_row row0;
        t_row row1;
        t_row row2;
        t_row row3;
        t_row row4;
        t_row row5;
        t_row row6;
        t_row row7;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tile_number;
        logic       flip_horizontal;
        logic       flip_vertical;
        logic       newly_stored;
        logic       store_overflow;
    } t_out_item;

    // Control carried from one compare cell to the next
    typedef struct packed {
        logic                  valid;
        logic [N_VARIANTS-1:0] match;
    } t_link;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_FINISH
    } t_state;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = b[7-k];
        end
        return r;
    endfunction

    // Horizontal mirror of one row: each plane byte reversed in place
    function automatic t_row rev_row(input t_row x);
        return {rev8(x[15:8]), rev8(x[7:0])};
    endfunction

endpackage

/* design/tile_dedup_with_mirroring.sv */
// ----------------------------------------------------------------------------
// tile_dedup_with_mirroring: tile deduplicator with flip matching
// Keeps a store of unique 8-row tiles and answers each tile with its index,
// flip flags and new/overflow status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_item) takes one tile per item.
//   Output channel (o_out_valid/i_out_ready/o_out_item) gives one result per
//   item. Configuration (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data) is
//   always ready; write it only while no item is in flight.
//   Search streams the store, one tile a cycle from the memory read port,
//   through a chain of eight row-compare cells that test all four variants
//   at once; the result is loaded once the chain has drained. Without a
//   search (dedup off or empty store) the result is loaded directly. The
//   next item is taken only after the result is loaded, so the block holds
//   one item in flight at a time.
//   Reset clears the tile count and restores the registers (two planes,
//   dedup on, mirroring off); memory contents need no clearing.
//   A finished result waits in the output register while the next item is
//   accepted and searched; a further result waits until the receiver takes
//   the held one.
// ----------------------------------------------------------------------------
module tile_dedup_with_mirroring #(
    parameter int STORE_TILES = tdm_pkg::STORE_TILES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tdm_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tdm_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tdm_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [tdm_pkg::CFG_DW-1:0]  i_cfg_data
);
    import tdm_pkg::*;

    localparam int AW = (STORE_TILES > 1) ? $clog2(STORE_TILES) : 1;
    localparam int CW = $clog2(STORE_TILES + 1);

    // configuration registers
    logic [1:0]      r_bpp;
    logic            r_dedup;
    logic            r_mirror;

    // sequencer and search state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_rd_addr;
    logic            r_rd_valid;
    logic [AW-1:0]   r_rd_idx;
    logic [TILE_ROWS-1:0][ROW_W-1:0] r_probe;
    logic [N_VARIANTS-1:0]           r_found;
    logic [AW-1:0]   r_found_idx [N_VARIANTS];

    // output register
    logic            r_ov;
    t_out_item       r_out, n_out;

    // control strobes
    logic            w_accept, w_rd_en, w_wr_en, w_load, w_busy, w_hit;
    logic            w_last_rd;
    logic [AW-1:0]   w_hit_idx;
    logic            w_hit_h, w_hit_v;
    t_tile           w_rd_data, w_wr_data;
    t_in_item        w_in;

    // chain links
    t_link           w_link [TILE_ROWS+1];
    logic [AW-1:0]   w_cidx [TILE_ROWS+1];
    t_tile           w_ctile [TILE_ROWS+1];
    t_probe          w_probe [TILE_ROWS];
    logic [TILE_ROWS-1:0] w_chain_valid;

    assign o_cfg_ready = 1'b1;
    assign w_in        = i_in_item;
    assign w_accept    = i_in_valid & o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= BPP_RESET;
            r_dedup  <= 1'b1;
            r_mirror <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BITS_PER_PIXEL: r_bpp    <= i_cfg_data[1:0];
                CFG_DEDUP_ENABLE:   r_dedup  <= i_cfg_data[0];
                CFG_MIRROR_ENABLE:  r_mirror <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture the probe tile, masked to one plane where asked
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                r_probe[r] <= (r_bpp == BPP_ONE_PLANE) ?
                              {8'h00, w_in[(TILE_ROWS-1-r)*ROW_W +: 8]} :
                              w_in[(TILE_ROWS-1-r)*ROW_W +: ROW_W];
            end
        end
    end

    // stored word: row r at bits [16r +: 16]
    always_comb begin
        for (int r = 0; r < TILE_ROWS; r++) begin
            w_wr_data[r*ROW_W +: ROW_W] = r_probe[r];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (r_dedup && (r_count != '0)) ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH: begin
                if (w_last_rd) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!w_busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ov || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_SEARCH: w_rd_en    = 1'b1;
            S_DRAIN:  ;
            S_FINISH: w_load     = !r_ov || i_out_ready;
            default:  ;
        endcase
    end

    assign w_last_rd = ((r_rd_addr + CW'(1)) == r_count);
    assign w_busy    = r_rd_valid | (|w_chain_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // read address sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr  <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_rd_en;
            if (w_accept) begin
                r_rd_addr <= '0;
            end else if (w_rd_en) begin
                r_rd_addr <= r_rd_addr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_rd_addr[AW-1:0];
    end

    tdm_store #(
        .AW    (AW),
        .DEPTH (STORE_TILES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // chain head
    assign w_link[0].valid = r_rd_valid;
    assign w_link[0].match = '1;
    assign w_cidx[0]       = r_rd_idx;
    assign w_ctile[0]      = w_rd_data;

    // row-compare chain: cell k checks row k of every variant
    for (genvar k = 0; k < TILE_ROWS; k++) begin : g_cell
        assign w_probe[k][V_PLAIN] = r_probe[k];
        assign w_probe[k][V_VFLIP] = r_probe[TILE_ROWS-1-k];
        assign w_probe[k][V_HFLIP] = rev_row(r_probe[k]);
        assign w_probe[k][V_BOTH]  = rev_row(r_probe[TILE_ROWS-1-k]);
        assign w_chain_valid[k]    = w_link[k+1].valid;

        tdm_cell #(
            .AW (AW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[k]),
            .i_link  (w_link[k]),
            .i_idx   (w_cidx[k]),
            .i_tile  (w_ctile[k]),
            .o_link  (w_link[k+1]),
            .o_idx   (w_cidx[k+1]),
            .o_tile  (w_ctile[k+1])
        );
    end

    // first match per variant; entries leave the chain in index order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= '0;
        end else if (w_accept) begin
            r_found <= '0;
        end else if (w_link[TILE_ROWS].valid) begin
            r_found <= r_found | w_link[TILE_ROWS].match;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int v = 0; v < N_VARIANTS; v++) begin
            if (w_link[TILE_ROWS].valid && w_link[TILE_ROWS].match[v] && !r_found[v]) begin
                r_found_idx[v] <= w_cidx[TILE_ROWS];
            end
        end
    end

    // pick the winning variant in search order
    always_comb begin
        w_hit     = 1'b0;
        w_hit_h   = 1'b0;
        w_hit_v   = 1'b0;
        w_hit_idx = r_found_idx[V_PLAIN];
        priority if (r_found[V_PLAIN]) begin
            w_hit = 1'b1;
        end else if (r_mirror && r_found[V_VFLIP]) begin
            w_hit     = 1'b1;
            w_hit_v   = 1'b1;
            w_hit_idx = r_found_idx[V_VFLIP];
        end else if (r_mirror && r_found[V_HFLIP]) begin
            w_hit     = 1'b1;
            w_hit_h   = 1'b1;
            w_hit_idx = r_found_idx[V_HFLIP];
        end else if (r_mirror && r_found[V_BOTH]) begin
            w_hit     = 1'b1;
            w_hit_h   = 1'b1;
            w_hit_v   = 1'b1;
            w_hit_idx = r_found_idx[V_BOTH];
        end else begin
            w_hit = 1'b0;
        end
    end

    // result and append decision
    always_comb begin
        n_out   = '0;
        w_wr_en = 1'b0;
        priority if (w_hit) begin
            n_out.tile_number     = 8'(w_hit_idx);
            n_out.flip_horizontal = w_hit_h;
            n_out.flip_vertical   = w_hit_v;
        end else if (r_count < CW'(STORE_TILES)) begin
            n_out.tile_number  = 8'(r_count);
            n_out.newly_stored = 1'b1;
            w_wr_en            = w_load;
        end else begin
            n_out.store_overflow = 1'b1;
        end
    end

    // tile count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= r_count + CW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_TILES))
        else $error("tile count above store depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CW'(1)))
        else $error("tile count moved by other than one");

    a_chain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_busy)
        else $error("item accepted while the compare chain is busy");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.newly_stored && o_out_item.store_overflow) &&
        !((o_out_item.newly_stored || o_out_item.store_overflow) &&
          (o_out_item.flip_horizontal || o_out_item.flip_vertical)))
        else $error("inconsistent result flags");

endmodule

/* design/tdm_store.sv */
// ----------------------------------------------------------------------------
// tdm_store: tile store memory
// One whole tile per word; one write port and one registered read port.
// ----------------------------------------------------------------------------
module tdm_store #(
    parameter int AW    = 8,
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  tdm_pkg::t_tile      i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output tdm_pkg::t_tile      o_rd_data
);
    import tdm_pkg::*;

    t_tile r_mem [DEPTH];
    t_tile r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/tdm_cell.sv */
// ----------------------------------------------------------------------------
// tdm_cell: one row-compare cell of the match chain
// Compares the lowest row of the passing stored tile against its four probe
// rows, narrows the match vector and hands tile, index and match on.
// ----------------------------------------------------------------------------
module tdm_cell #(
    parameter int AW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tdm_pkg::t_probe     i_probe,
    input  tdm_pkg::t_link      i_link,
    input  logic [AW-1:0]       i_idx,
    input  tdm_pkg::t_tile      i_tile,
    output tdm_pkg::t_link      o_link,
    output logic [AW-1:0]       o_idx,
    output tdm_pkg::t_tile      o_tile
);
    import tdm_pkg::*;

    t_link           r_link, n_link;
    logic [AW-1:0]   r_idx;
    t_tile           r_tile, n_tile;
    logic [N_VARIANTS-1:0] w_hit;

    // row compare against each variant
    always_comb begin
        for (int v = 0; v < N_VARIANTS; v++) begin
            w_hit[v] = (i_tile[ROW_W-1:0] == i_probe[v]);
        end
        n_link.valid = i_link.valid;
        n_link.match = i_link.match & w_hit;
        // next cell sees the following row at the bottom
        n_tile = {{ROW_W{1'b0}}, i_tile[TILE_W-1:ROW_W]};
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_tile <= n_tile;
    end

    assign o_link = r_link;
    assign o_idx  = r_idx;
    assign o_tile = r_tile;

endmodule
